// ----- rtl/remote_control_frame_decoder_assert.svh -----
// Assertion macros for the remote-control frame decoder.
// Each check is clocked on clk and disabled while arst_n is low.
`ifndef REMOTE_CONTROL_FRAME_DECODER_ASSERT_SVH
`define REMOTE_CONTROL_FRAME_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define RCFD_ASSERT_SAME(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);
`define RCFD_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);
`else
`define RCFD_ASSERT_SAME(label, cond, expr, msg)
`define RCFD_ASSERT_NEXT(label, cond, expr, msg)
`endif

`endif

// ----- rtl/rcfd_pkg.sv -----
`default_nettype none
package rcfd_pkg;

	localparam int FRAME_LEN = 18;
	localparam int COUNT_W   = $clog2(FRAME_LEN + 2);

	localparam logic [1:0] REQ_BYTE = 2'd0;
	localparam logic [1:0] REQ_GAP  = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

	localparam logic [10:0] CH_MIN     = 11'd364;
	localparam logic [10:0] CH_MAX     = 11'd1684;
	localparam logic [10:0] CH_DEFAULT = 11'd1024;
	localparam logic [3:0]  SW_LEFT    = 4'hC;
	localparam logic [3:0]  SW_RIGHT   = 4'h3;
	localparam logic [3:0]  SW_DEFAULT = 4'd10;

	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	typedef logic [FRAME_LEN-1:0][7:0] frame_t;

	typedef struct packed {
		logic wr_byte;
		logic clear_count;
	} store_ctrl_t;

	typedef struct packed {
		logic [10:0]        stick_0;
		logic [10:0]        stick_1;
		logic [10:0]        stick_2;
		logic [10:0]        stick_3;
		logic [10:0]        wheel;
		logic [3:0]         switches;
		logic signed [15:0] mouse_x;
		logic signed [15:0] mouse_y;
		logic signed [15:0] mouse_z;
		logic [15:0]        mouse_buttons;
		logic [15:0]        keys;
		logic [1:0]         status;
	} result_t;

	function automatic result_t default_result(input logic [1:0] st);
		result_t r;
		r.stick_0       = CH_DEFAULT;
		r.stick_1       = CH_DEFAULT;
		r.stick_2       = CH_DEFAULT;
		r.stick_3       = CH_DEFAULT;
		r.wheel         = CH_DEFAULT;
		r.switches      = SW_DEFAULT;
		r.mouse_x       = '0;
		r.mouse_y       = '0;
		r.mouse_z       = '0;
		r.mouse_buttons = '0;
		r.keys          = '0;
		r.status        = st;
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rcfd_frame_store.sv -----
`default_nettype none
module rcfd_frame_store
	import rcfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire store_ctrl_t ctrl,
	input  wire logic [7:0]  wr_data,
	output      frame_t      frame,
	output      logic        full
);

	frame_t             bytes_q;
	logic [COUNT_W-1:0] count_q;

	// Bytes past the frame length are dropped; the count parks one above
	// the length so the burst is rejected at the gap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.clear_count) begin
			count_q <= '0;
		end else if (ctrl.wr_byte) begin
			if (count_q < COUNT_W'(FRAME_LEN)) begin
				count_q <= count_q + COUNT_W'(1);
			end else begin
				count_q <= COUNT_W'(FRAME_LEN + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_byte && !ctrl.clear_count && count_q < COUNT_W'(FRAME_LEN)) begin
			bytes_q[count_q] <= wr_data;
		end
	end

	assign frame = bytes_q;
	assign full  = (count_q == COUNT_W'(FRAME_LEN));

endmodule
`default_nettype wire

// ----- rtl/rcfd_decode.sv -----
`default_nettype none
module rcfd_decode
	import rcfd_pkg::*;
(
	input  wire frame_t  frame,
	output      result_t dec,
	output      logic    ok
);

	logic [4:0][10:0] ch;
	logic [3:0]       sw;
	logic [4:0]       ch_ok;

	always_comb begin
		ch[0] = {frame[1][2:0], frame[0]};
		ch[1] = {frame[2][5:0], frame[1][7:3]};
		ch[2] = {frame[4][0], frame[3], frame[2][7:6]};
		ch[3] = {frame[5][3:0], frame[4][7:1]};
		ch[4] = {frame[17][2:0], frame[16]};
		sw    = frame[5][7:4];
		for (int i = 0; i < 5; i++) begin
			ch_ok[i] = (ch[i] >= CH_MIN) && (ch[i] <= CH_MAX);
		end
	end

	assign ok = (&ch_ok) && ((sw & SW_LEFT) != 4'd0) && ((sw & SW_RIGHT) != 4'd0);

	always_comb begin
		dec.stick_0       = ch[0];
		dec.stick_1       = ch[1];
		dec.stick_2       = ch[2];
		dec.stick_3       = ch[3];
		dec.wheel         = ch[4];
		dec.switches      = sw;
		dec.mouse_x       = {frame[7], frame[6]};
		dec.mouse_y       = {frame[9], frame[8]};
		dec.mouse_z       = {frame[11], frame[10]};
		dec.mouse_buttons = {frame[13], frame[12]};
		dec.keys          = {frame[15], frame[14]};
		dec.status        = STATUS_OK;
	end

endmodule
`default_nettype wire

// ----- rtl/rcfd_watchdog.sv -----
`default_nettype none
module rcfd_watchdog
	import rcfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        tick,
	input  wire logic        feed,
	input  wire logic [15:0] timeout_ticks,
	output      logic        expire
);

	logic [15:0] idle_q;
	logic [16:0] next_count;

	// A timeout of zero expires on every tick, the same as one.
	assign next_count = {1'b0, idle_q} + 17'd1;
	assign expire     = tick && (next_count >= {1'b0, timeout_ticks});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= '0;
		end else if (tick) begin
			idle_q <= expire ? 16'd0 : next_count[15:0];
		end else if (feed) begin
			idle_q <= '0;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/remote_control_frame_decoder.sv -----
// Decodes 18-byte remote-control frames from a stream of received bytes, frame-gap
// markers and time ticks. Each input word is taken into an input register and
// processed from there against the frame store, the halt flag and the tick
// watchdog; a gap that closes a full frame while not halted or a tick that expires
// the watchdog loads the result register. One word is accepted per clock; a stalled
// result holds back the input only when the input register is also occupied.
// Invalid frames emit defaults with invalid status and halt reception until the
// watchdog expires. The watchdog limit is written through cfg_we and cfg_wdata;
// the user must write it only while the block is idle; nothing enforces it.
`default_nettype none
`include "remote_control_frame_decoder_assert.svh"
module remote_control_frame_decoder
	import rcfd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [15:0]        cfg_wdata,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic [1:0]         req_type,
	input  wire logic [7:0]         rx_byte,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic [10:0]        stick_0,
	output      logic [10:0]        stick_1,
	output      logic [10:0]        stick_2,
	output      logic [10:0]        stick_3,
	output      logic [10:0]        wheel,
	output      logic [3:0]         switches,
	output      logic signed [15:0] mouse_x,
	output      logic signed [15:0] mouse_y,
	output      logic signed [15:0] mouse_z,
	output      logic [15:0]        mouse_buttons,
	output      logic [15:0]        keys,
	output      logic [1:0]         status
);

	logic [15:0] timeout_q;
	logic        halted_q;
	logic        valid_s1;
	logic [1:0]  req_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	result_t     res_q;

	logic        advance;
	logic        go;
	logic        is_byte;
	logic        is_gap;
	logic        is_tick;
	logic        emit_gap;
	logic        emit;
	logic        expire;
	logic        full;
	logic        dec_ok;
	frame_t      frame;
	result_t     dec;
	result_t     result;
	store_ctrl_t store_ctrl;

	// The processing stage moves whenever the result register is free or being read.
	assign advance  = !(out_valid_q && !out_ready);
	assign go       = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		is_byte = 1'b0;
		is_gap  = 1'b0;
		is_tick = 1'b0;
		unique case (req_s1)
			REQ_BYTE: is_byte = go;
			REQ_GAP:  is_gap  = go;
			REQ_TICK: is_tick = go;
			default:  ;
		endcase
	end

	assign emit_gap = is_gap && !halted_q && full;
	assign emit     = emit_gap || expire;

	assign store_ctrl.wr_byte     = is_byte && !halted_q;
	assign store_ctrl.clear_count = is_gap || expire;

	rcfd_frame_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (store_ctrl),
		.wr_data (byte_s1),
		.frame   (frame),
		.full    (full)
	);

	rcfd_decode u_decode (
		.frame (frame),
		.dec   (dec),
		.ok    (dec_ok)
	);

	rcfd_watchdog u_watchdog (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick          (is_tick),
		.feed          (emit_gap && dec_ok),
		.timeout_ticks (timeout_q),
		.expire        (expire)
	);

	always_comb begin
		priority if (expire) begin
			result = default_result(STATUS_TIMEOUT);
		end else if (dec_ok) begin
			result = dec;
		end else begin
			result = default_result(STATUS_INVALID);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
		end else if (expire) begin
			halted_q <= 1'b0;
		end else if (emit_gap && !dec_ok) begin
			halted_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1  <= req_type;
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign stick_0       = res_q.stick_0;
	assign stick_1       = res_q.stick_1;
	assign stick_2       = res_q.stick_2;
	assign stick_3       = res_q.stick_3;
	assign wheel         = res_q.wheel;
	assign switches      = res_q.switches;
	assign mouse_x       = res_q.mouse_x;
	assign mouse_y       = res_q.mouse_y;
	assign mouse_z       = res_q.mouse_z;
	assign mouse_buttons = res_q.mouse_buttons;
	assign keys          = res_q.keys;
	assign status        = res_q.status;

	`RCFD_ASSERT_SAME(a_no_overwrite, out_valid_q && !out_ready, !emit, "result overwritten while stalled")
	`RCFD_ASSERT_SAME(a_halt_gap_silent, halted_q && is_gap, !emit, "gap produced a word while halted")
	`RCFD_ASSERT_NEXT(a_invalid_halts, emit && !expire && !dec_ok, halted_q, "invalid frame did not halt")
	`RCFD_ASSERT_NEXT(a_stage_holds, valid_s1 && !advance, valid_s1 && $stable(req_s1), "stage lost its word")

endmodule
`default_nettype wire
